@@ hw/rtl/rmv_pkg.sv @@
// ----------------------------------------------------------------------------
// rmv_pkg: shared definitions for the running mean / variance block
// Widths, command codes, sequencer states and the status word of the units.
// ----------------------------------------------------------------------------
package rmv_pkg;

  // sample count width, 8..48
  localparam int unsigned CountBits = 32;

  // fixed field widths
  localparam int unsigned SampleW = 32;
  localparam int unsigned SumW    = 64;
  localparam int unsigned RootW   = 32;
  localparam int unsigned OutW    = 160;

  // input command codes carried on tuser
  localparam logic CmdPush  = 1'b0;
  localparam logic CmdClear = 1'b1;

  // one quotient bit per step over the full 64-bit dividend
  localparam int unsigned DivSteps = 64;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // two radicand bits per step
  localparam int unsigned RootSteps = 32;
  localparam int unsigned RootCntW  = $clog2(RootSteps);

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StMeanDiv,
    StMult,
    StAccum,
    StVarDiv,
    StRoot,
    StDone
  } rmv_state_e;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } rmv_unit_sts_t;

endpackage

@@ hw/rtl/rmv_div.sv @@
// ----------------------------------------------------------------------------
// rmv_div: restoring divider, one quotient bit per cycle
// 64-bit dividend over a count-wide divisor; done pulses after 64 steps.
// ----------------------------------------------------------------------------
module rmv_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rmv_pkg::SumW-1:0]        dividend_i,
  input  logic [rmv_pkg::CountBits-1:0]   divisor_i,
  output rmv_pkg::rmv_unit_sts_t          sts_o,
  output logic [rmv_pkg::SumW-1:0]        quotient_o
);

  localparam int unsigned Cb = rmv_pkg::CountBits;
  localparam int unsigned Sw = rmv_pkg::SumW;
  localparam int unsigned Cw = rmv_pkg::DivCntW;

  logic          busy_q, done_q;
  logic [Cw-1:0] cnt_q;
  logic [Cb-1:0] rem_q, dvs_q;
  logic [Sw-1:0] quo_q;

  logic [Cb:0]   shift_w, diff_w;
  logic          ge_w;
  logic [Cb-1:0] rem_next_w;

  // trial subtract of the divisor from the shifted remainder
  assign shift_w    = {rem_q, quo_q[Sw-1]};
  assign ge_w       = shift_w >= {1'b0, dvs_q};
  assign diff_w     = shift_w - {1'b0, dvs_q};
  assign rem_next_w = ge_w ? diff_w[Cb-1:0] : shift_w[Cb-1:0];

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= Cw'(rmv_pkg::DivSteps - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // datapath: dividend shifts out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_next_w;
      quo_q <= {quo_q[Sw-2:0], ge_w};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hw/rtl/rmv_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmv_sqrt: digit-by-digit integer square root
// Truncated root of a 64-bit value, one root bit per cycle over 32 steps.
// ----------------------------------------------------------------------------
module rmv_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rmv_pkg::SumW-1:0]    value_i,
  output rmv_pkg::rmv_unit_sts_t      sts_o,
  output logic [rmv_pkg::RootW-1:0]   root_o
);

  localparam int unsigned Sw = rmv_pkg::SumW;
  localparam int unsigned Rw = rmv_pkg::RootW;
  localparam int unsigned Cw = rmv_pkg::RootCntW;

  logic          busy_q, done_q;
  logic [Cw-1:0] cnt_q;
  logic [Sw-1:0] val_q;
  logic [Rw:0]   rem_q;
  logic [Rw-1:0] root_q;

  logic [Rw+2:0] shift_w, trial_w, diff_w;
  logic          ge_w;

  // bring down two bits, try 4*root+1
  assign shift_w = {rem_q, val_q[Sw-1:Sw-2]};
  assign trial_w = {1'b0, root_q, 2'b01};
  assign ge_w    = shift_w >= trial_w;
  assign diff_w  = shift_w - trial_w;

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= Cw'(rmv_pkg::RootSteps - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[Sw-3:0], 2'b00};
      rem_q  <= ge_w ? diff_w[Rw:0] : shift_w[Rw:0];
      root_q <= {root_q[Rw-2:0], ge_w};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;

endmodule

@@ hw/rtl/running_mean_variance.sv @@
// ----------------------------------------------------------------------------
// running_mean_variance: Welford running count, mean, variance and deviation
// Clears or pushes one Q15.16 sample per word and reports one stats word.
// ----------------------------------------------------------------------------
// Flow: a clear or a first push goes through StSetup and StDone to the
//   output register; other pushes also pass the 64-step mean divide, the
//   multiply, accumulate, 64-step variance divide and 32-step root (iterative units).
// A new word waits until the last one leaves StDone; tready is high only idle.
// Reset: asynchronous, active low; count, mean and sum return to zero.
// ----------------------------------------------------------------------------
module running_mean_variance (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [31:0]                 s_axis_tdata_i,  // [31:0] sample
  input  logic                        s_axis_tuser_i,  // [0] cmd
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [31:0] sample_count, [63:32] mean_value, [127:64] variance_value,
  // [159:128] deviation_value
  output logic [rmv_pkg::OutW-1:0]    m_axis_tdata_o,
  output logic                        m_axis_tuser_o   // [0] saturated
);

  localparam int unsigned Cb = rmv_pkg::CountBits;
  localparam int unsigned Xw = rmv_pkg::SampleW;
  localparam int unsigned Sw = rmv_pkg::SumW;
  localparam int unsigned Rw = rmv_pkg::RootW;
  localparam logic [Cb-1:0] CountMax = '1;

  rmv_pkg::rmv_state_e state_q, state_d;

  // statistics
  logic [Cb-1:0] count_q, count_d;
  logic [Xw-1:0] mean_q, mean_d;
  logic [Sw-1:0] sum_q, sum_d;

  // item and intermediates
  logic          cmd_q;
  logic [Xw-1:0] sample_q;
  logic [Xw-1:0] mag1_q, mag1_d;
  logic          neg_q, neg_d;
  logic [Sw-1:0] prod_q, prod_d;
  logic [Sw-1:0] var_q, var_d;
  logic [Rw-1:0] dev_q, dev_d;

  // output register
  logic                     out_vld_q, out_vld_d;
  logic [rmv_pkg::OutW-1:0] out_data_q;
  logic                     out_sat_q;
  logic                     load_out;

  // unit hookup
  logic                   div_start, root_start;
  logic [Sw-1:0]          div_dividend, div_quo;
  logic [Cb-1:0]          div_divisor;
  logic [Rw-1:0]          root_res;
  rmv_pkg::rmv_unit_sts_t div_sts, root_sts;

  // datapath helpers
  logic          in_acc;
  logic [Cb-1:0] count_inc;
  logic [Xw:0]   d1_w, d2_w, mag1_w, mag2_w;
  logic [Xw:0]   step_w, new_mean_w;
  logic [Sw-1:0] prod_w;
  logic [Sw:0]   sum_add_w;
  logic [Sw-1:0] sum_sat_w;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;

  // first deviation against the old mean
  assign d1_w   = {sample_q[Xw-1], sample_q} - {mean_q[Xw-1], mean_q};
  assign mag1_w = d1_w[Xw] ? (Xw+1)'(0) - d1_w : d1_w;

  // mean moves by the truncated quotient, toward the sample
  assign step_w     = neg_q ? (Xw+1)'(0) - {1'b0, div_quo[Xw-1:0]}
                            : {1'b0, div_quo[Xw-1:0]};
  assign new_mean_w = {mean_q[Xw-1], mean_q} + step_w;

  // second deviation against the new mean, same sign as the first
  assign d2_w   = {sample_q[Xw-1], sample_q} - {mean_q[Xw-1], mean_q};
  assign mag2_w = d2_w[Xw] ? (Xw+1)'(0) - d2_w : d2_w;
  assign prod_w = mag1_q * mag2_w[Xw-1:0];

  // saturating accumulate
  assign sum_add_w = {1'b0, sum_q} + {1'b0, prod_q};
  assign sum_sat_w = sum_add_w[Sw] ? '1 : sum_add_w[Sw-1:0];

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    mean_d       = mean_q;
    sum_d        = sum_q;
    mag1_d       = mag1_q;
    neg_d        = neg_q;
    prod_d       = prod_q;
    var_d        = var_q;
    dev_d        = dev_q;
    div_start    = 1'b0;
    div_dividend = {{(Sw-Xw){1'b0}}, mag1_w[Xw-1:0]};
    div_divisor  = count_inc;
    root_start   = 1'b0;
    load_out     = 1'b0;
    out_vld_d    = out_vld_q && !m_axis_tready_i;

    case (state_q)
      rmv_pkg::StIdle: begin
        if (in_acc) begin
          state_d = rmv_pkg::StSetup;
        end
      end
      rmv_pkg::StSetup: begin
        if (cmd_q == rmv_pkg::CmdClear) begin
          count_d = '0;
          mean_d  = '0;
          sum_d   = '0;
          var_d   = '0;
          dev_d   = '0;
          state_d = rmv_pkg::StDone;
        end else if (count_inc == Cb'(1)) begin
          // first sample sets the mean outright
          count_d = count_inc;
          mean_d  = sample_q;
          sum_d   = '0;
          var_d   = '0;
          dev_d   = '0;
          state_d = rmv_pkg::StDone;
        end else begin
          count_d   = count_inc;
          mag1_d    = mag1_w[Xw-1:0];
          neg_d     = d1_w[Xw];
          div_start = 1'b1;
          state_d   = rmv_pkg::StMeanDiv;
        end
      end
      rmv_pkg::StMeanDiv: begin
        if (div_sts.done) begin
          mean_d  = new_mean_w[Xw-1:0];
          state_d = rmv_pkg::StMult;
        end
      end
      rmv_pkg::StMult: begin
        prod_d  = prod_w;
        state_d = rmv_pkg::StAccum;
      end
      rmv_pkg::StAccum: begin
        // count is at least two here
        sum_d        = sum_sat_w;
        div_start    = 1'b1;
        div_dividend = sum_sat_w;
        div_divisor  = count_q - 1'b1;
        state_d      = rmv_pkg::StVarDiv;
      end
      rmv_pkg::StVarDiv: begin
        if (div_sts.done) begin
          var_d      = div_quo;
          root_start = 1'b1;
          state_d    = rmv_pkg::StRoot;
        end
      end
      rmv_pkg::StRoot: begin
        if (root_sts.done) begin
          dev_d   = root_res;
          state_d = rmv_pkg::StDone;
        end
      end
      rmv_pkg::StDone: begin
        if (!out_vld_q || m_axis_tready_i) begin
          load_out  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = rmv_pkg::StIdle;
        end
      end
      default: begin
        state_d = rmv_pkg::StIdle;
      end
    endcase
  end

  // control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rmv_pkg::StIdle;
      count_q   <= '0;
      mean_q    <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      mean_q    <= mean_d;
      sum_q     <= sum_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= s_axis_tuser_i;
      sample_q <= s_axis_tdata_i;
    end
    mag1_q <= mag1_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    var_q  <= var_d;
    dev_q  <= dev_d;
    if (load_out) begin
      out_data_q <= {dev_q, var_q, mean_q, 32'(count_q)};
      out_sat_q  <= (count_q == CountMax) || (sum_q == '1);
    end
  end

  rmv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (div_quo)
  );

  rmv_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (div_quo),
    .sts_o   (root_sts),
    .root_o  (root_res)
  );

  assign s_axis_tready_o = (state_q == rmv_pkg::StIdle);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sat_q;

  // units are quiet whenever a new word can be taken
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_sts.busy && !root_sts.busy)
    else $error("iterative unit busy while idle");

  // divider finishes only where the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == rmv_pkg::StMeanDiv || state_q == rmv_pkg::StVarDiv))
    else $error("divider done outside a divide state");

  // root finishes only in its wait state
  a_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_sts.done |-> state_q == rmv_pkg::StRoot)
    else $error("root done outside root state");

  // no squared deviation without two samples
  a_sum_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == Cb'(1)) |-> sum_q == '0)
    else $error("deviation sum nonzero below two samples");

endmodule
